FILE: rtl/core/sfr_pkg.sv
package sfr_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hE0;
  localparam logic [7:0] MARK_BYTE   = 8'hD0;
  localparam logic [7:0] BCAST_ADDR  = 8'hFF;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] CMD_SETADDR = 8'hF1;
  localparam logic [7:0] RESET_ARG   = 8'hD9;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DEST = 2'd1;
  localparam logic [1:0] PH_SIZE = 2'd2;
  localparam logic [1:0] PH_BODY = 2'd3;

  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_GOOD  = 2'd1;
  localparam logic [1:0] EV_CSUM  = 2'd2;
  localparam logic [1:0] EV_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] data;
    logic       broadcast;
    logic [7:0] current_address;
    logic       address_changed;
  } res_t;

endpackage

FILE: rtl/core/serial_frame_receiver.sv
// Serial frame receiver.
// Input channel (in_valid/in_ready/in_rx_byte): one raw line byte per beat.
// Bytes are dropped until sync 0xE0; the frame after it is unescaped
// (0xD0 marks the next byte plus one) and parsed as destination, size,
// data bytes and checksum.
// Output channel (out_valid/out_ready/out_*): at most one beat per input
// byte: a data beat for each payload byte of a frame addressed to this node
// or to broadcast, and one frame-end beat per frame (good, checksum error,
// empty). On checksum error the consumer drops the data of that frame.
// Each result is registered in the output register or the skid register.
// Throughput: one byte per cycle while in_ready is high.
// The output register is backed by a one-beat skid register, so in_ready
// is registered and the receiver keeps taking bytes while one result waits.
// When both hold a beat, in_ready drops until the consumer takes one.
// Reset (rst_n low, synchronous): back to waiting for sync, node address 0,
// output empty.
module serial_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_res,
  output logic [7:0] out_data,
  output logic       out_broadcast,
  output logic [7:0] out_current_address,
  output logic       out_address_changed
);

  logic [1:0] phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] dest_r, dest_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] pay0_r, pay0_nxt;
  logic [7:0] pay1_r, pay1_nxt;
  logic [1:0] seen_r, seen_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  sfr_pkg::res_t out_r, out_nxt;
  sfr_pkg::res_t skid_r, skid_nxt;

  logic          accept;
  logic          produce;
  sfr_pkg::res_t res;
  logic [7:0]    v;
  logic          bcast;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign bcast    = (dest_r == sfr_pkg::BCAST_ADDR);

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    dest_nxt  = dest_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    addr_nxt  = addr_r;
    pay0_nxt  = pay0_r;
    pay1_nxt  = pay1_r;
    seen_nxt  = seen_r;
    produce   = 1'b0;
    res       = '0;
    res.broadcast = bcast;
    v = esc_r ? in_rx_byte + 8'd1 : in_rx_byte;

    if (accept) begin
      if (phase_r == sfr_pkg::PH_IDLE) begin
        if (in_rx_byte == sfr_pkg::SYNC_BYTE) begin
          phase_nxt = sfr_pkg::PH_DEST;
          esc_nxt   = 1'b0;
        end
      end else if (!esc_r && in_rx_byte == sfr_pkg::MARK_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        unique case (phase_r)
          sfr_pkg::PH_DEST: begin
            dest_nxt  = v;
            sum_nxt   = v;
            seen_nxt  = 2'd0;
            pay0_nxt  = '0;
            pay1_nxt  = '0;
            phase_nxt = sfr_pkg::PH_SIZE;
          end
          sfr_pkg::PH_SIZE: begin
            sum_nxt  = sum_r + v;
            left_nxt = v;
            if (v == 8'd0) begin
              phase_nxt     = sfr_pkg::PH_IDLE;
              produce       = 1'b1;
              res.event_res = sfr_pkg::EV_EMPTY;
            end else begin
              phase_nxt = sfr_pkg::PH_BODY;
            end
          end
          default: begin
            if (left_r > 8'd1) begin
              left_nxt = left_r - 8'd1;
              sum_nxt  = sum_r + v;
              if (seen_r == 2'd0) pay0_nxt = v;
              else if (seen_r == 2'd1) pay1_nxt = v;
              if (seen_r < 2'd2) seen_nxt = seen_r + 2'd1;
              if (bcast || dest_r == addr_r) begin
                produce       = 1'b1;
                res.event_res = sfr_pkg::EV_DATA;
                res.data      = v;
              end
            end else begin
              // checksum byte closes the frame
              left_nxt  = '0;
              phase_nxt = sfr_pkg::PH_IDLE;
              produce   = 1'b1;
              if (v != sum_r) begin
                res.event_res = sfr_pkg::EV_CSUM;
              end else begin
                res.event_res = sfr_pkg::EV_GOOD;
                if (bcast && seen_r == 2'd2) begin
                  if (pay0_r == sfr_pkg::CMD_RESET && pay1_r == sfr_pkg::RESET_ARG) begin
                    addr_nxt            = '0;
                    res.address_changed = 1'b1;
                  end else if (pay0_r == sfr_pkg::CMD_SETADDR) begin
                    addr_nxt            = pay1_r;
                    res.address_changed = 1'b1;
                  end
                end
              end
            end
          end
        endcase
      end
    end
    res.current_address = addr_nxt;
  end

  // output register with one-beat skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = produce;
        out_nxt       = res;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sfr_pkg::PH_IDLE;
      esc_r        <= 1'b0;
      dest_r       <= '0;
      left_r       <= '0;
      sum_r        <= '0;
      addr_r       <= '0;
      pay0_r       <= '0;
      pay1_r       <= '0;
      seen_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      esc_r        <= esc_nxt;
      dest_r       <= dest_nxt;
      left_r       <= left_nxt;
      sum_r        <= sum_nxt;
      addr_r       <= addr_nxt;
      pay0_r       <= pay0_nxt;
      pay1_r       <= pay1_nxt;
      seen_r       <= seen_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_r.event_res;
  assign out_data            = out_r.data;
  assign out_broadcast       = out_r.broadcast;
  assign out_current_address = out_r.current_address;
  assign out_address_changed = out_r.address_changed;

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int N_ITEMS = 1700;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_res;
  logic [7:0] out_data;
  logic       out_broadcast;
  logic [7:0] out_current_address;
  logic       out_address_changed;

  serial_frame_receiver dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_data            (out_data),
    .out_broadcast       (out_broadcast),
    .out_current_address (out_current_address),
    .out_address_changed (out_address_changed)
  );

  always #5 clk = ~clk;

  // line bytes waiting to be sent, and the decoded beats the block owes us
  logic [7:0] line_q[$];
  logic [7:0] frame_q[$];
  logic [7:0] payload_q[$];
  res_t       expected_beats[$];

  int  send_idle = 0;
  int  recv_idle = 0;
  bit  hold_req = 1'b0;
  bit  hold_off = 1'b0;
  int  errors = 0;
  int  n_items = 0;
  int  n_frames = 0;
  int  n_accepted = 0;
  int  n_addr_updates = 0;
  int  ev_seen[4] = '{0, 0, 0, 0};
  logic [7:0] gen_addr = 8'h00;
  res_t want;

  // decoder shadow state
  logic [1:0] rx_phase = PH_IDLE;
  logic       rx_esc = 1'b0;
  logic [7:0] rx_dest = 8'h00;
  logic [7:0] rx_left = 8'h00;
  logic [7:0] rx_sum = 8'h00;
  logic [7:0] rx_addr = 8'h00;
  logic [7:0] cmd_byte = 8'h00;
  logic [7:0] arg_byte = 8'h00;
  logic [1:0] rx_seen = 2'd0;

  function automatic void post(logic [1:0] ev, logic [7:0] d, logic chg);
    res_t r;
    r.event_res       = ev;
    r.data            = d;
    r.broadcast       = (rx_dest == BCAST_ADDR);
    r.current_address = rx_addr;
    r.address_changed = chg;
    expected_beats.push_back(r);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] v;
    logic       chg;
    if (rx_phase == PH_IDLE) begin
      if (b == SYNC_BYTE) begin
        rx_phase = PH_DEST;
        rx_esc   = 1'b0;
      end
      return;
    end
    if (rx_esc) begin
      rx_esc = 1'b0;
      v = b + 8'd1;
    end else if (b == MARK_BYTE) begin
      rx_esc = 1'b1;
      return;
    end else begin
      v = b;
    end
    case (rx_phase)
      PH_DEST: begin
        rx_dest  = v;
        rx_sum   = v;
        rx_seen  = 2'd0;
        cmd_byte = 8'h00;
        arg_byte = 8'h00;
        rx_phase = PH_SIZE;
      end
      PH_SIZE: begin
        rx_sum  = rx_sum + v;
        rx_left = v;
        if (v == 8'h00) begin
          rx_phase = PH_IDLE;
          post(EV_EMPTY, 8'h00, 1'b0);
        end else begin
          rx_phase = PH_BODY;
        end
      end
      default: begin
        if (rx_left > 8'd1) begin
          rx_left = rx_left - 8'd1;
          rx_sum  = rx_sum + v;
          if (rx_seen == 2'd0) cmd_byte = v;
          else if (rx_seen == 2'd1) arg_byte = v;
          if (rx_seen < 2'd2) rx_seen = rx_seen + 2'd1;
          if (rx_dest == BCAST_ADDR || rx_dest == rx_addr) post(EV_DATA, v, 1'b0);
        end else begin
          // checksum byte closes the frame
          rx_left  = 8'h00;
          rx_phase = PH_IDLE;
          if (v != rx_sum) begin
            post(EV_CSUM, 8'h00, 1'b0);
          end else begin
            chg = 1'b0;
            if (rx_dest == BCAST_ADDR && rx_seen == 2'd2) begin
              if (cmd_byte == CMD_RESET && arg_byte == RESET_ARG) begin
                rx_addr = 8'h00;
                chg = 1'b1;
              end else if (cmd_byte == CMD_SETADDR) begin
                rx_addr = arg_byte;
                chg = 1'b1;
              end
            end
            post(EV_GOOD, 8'h00, chg);
          end
        end
      end
    endcase
  endtask

  function automatic logic [7:0] any_byte();
    case ($urandom_range(15))
      0: return SYNC_BYTE;
      1: return MARK_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // marks must be escaped; other values get escaped now and then
  function automatic void put_escaped(logic [7:0] v);
    logic [7:0] lower;
    lower = v - 8'd1;
    if (v == MARK_BYTE || $urandom_range(5) == 0) begin
      frame_q.push_back(MARK_BYTE);
      frame_q.push_back(lower);
    end else begin
      frame_q.push_back(v);
    end
  endfunction

  // payload_q holds the data bytes; cut < 0 sends the whole frame
  task automatic send_frame(input logic [7:0] dest, input logic [7:0] size,
                            input bit bad_sum, input int cut);
    logic [7:0] sum;
    sum = dest + size;
    frame_q.delete();
    frame_q.push_back(SYNC_BYTE);
    put_escaped(dest);
    put_escaped(size);
    foreach (payload_q[i]) begin
      put_escaped(payload_q[i]);
      sum = sum + payload_q[i];
    end
    if (size != 8'h00) put_escaped(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
    if (cut < 0 || cut > frame_q.size()) cut = frame_q.size();
    for (int i = 0; i < cut; i++) line_q.push_back(frame_q[i]);
    n_items += cut;
    n_frames++;
  endtask

  task automatic random_frame();
    int         pick;
    int         n;
    int         cut;
    bit         bad;
    logic [7:0] dest;
    logic [7:0] size;
    logic [7:0] arg;
    payload_q.delete();
    pick = $urandom_range(99);
    if (pick < 40) dest = BCAST_ADDR;
    else if (pick < 75) dest = gen_addr;
    else dest = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : any_byte();
    if (dest == BCAST_ADDR && $urandom_range(99) < 60) begin
      arg = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : any_byte();
      case ($urandom_range(5))
        0, 1: payload_q = '{CMD_SETADDR, arg};
        2: payload_q = '{CMD_RESET, RESET_ARG};
        3: payload_q = '{CMD_RESET, arg};
        4: payload_q.push_back(($urandom_range(1) == 0) ? CMD_SETADDR : CMD_RESET);
        default: payload_q = '{any_byte(), arg};
      endcase
      repeat ($urandom_range(2)) payload_q.push_back(any_byte());
    end else begin
      if ($urandom_range(99) == 0) n = 254;
      else if ($urandom_range(9) == 0) n = $urandom_range(60, 8);
      else n = $urandom_range(7);
      repeat (n) payload_q.push_back(any_byte());
    end
    if (payload_q.size() == 0 && $urandom_range(3) == 0) size = 8'h00;
    else size = 8'(payload_q.size() + 1);
    bad = ($urandom_range(7) == 0);
    cut = ($urandom_range(29) == 0) ? $urandom_range(4, 1) : -1;
    if (!bad && cut < 0 && dest == BCAST_ADDR && payload_q.size() >= 2) begin
      if (payload_q[0] == CMD_RESET && payload_q[1] == RESET_ARG) gen_addr = 8'h00;
      else if (payload_q[0] == CMD_SETADDR) gen_addr = payload_q[1];
    end
    send_frame(dest, size, bad, cut);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_rx_byte);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (line_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid   <= 1'b1;
          in_rx_byte <= line_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual event %0d data %0h",
                   $time, out_event_res, out_data);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("event_res", want.event_res, out_event_res);
          check_field("data", want.data, out_data);
          check_field("broadcast", want.broadcast, out_broadcast);
          check_field("current_address", want.current_address, out_current_address);
          check_field("address_changed", want.address_changed, out_address_changed);
          ev_seen[out_event_res]++;
          if (out_address_changed) n_addr_updates++;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // long consumer stall while the line keeps offering bytes
  initial begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 3; p++) begin
      @(negedge clk);
      send_idle = (p == 0) ? 26 : (p == 1) ? 72 : 0;
      recv_idle = (p == 0) ? 72 : (p == 1) ? 26 : 0;
      if (p == 0) begin
        // noise before sync, then address set, own-node data with sync and
        // mark values inside, empty frame, bad checksum to another node, reset
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        payload_q = '{CMD_SETADDR, 8'h05};
        send_frame(BCAST_ADDR, 8'd3, 1'b0, -1);
        payload_q = '{SYNC_BYTE, MARK_BYTE, 8'h00};
        send_frame(8'h05, 8'd4, 1'b0, -1);
        payload_q.delete();
        send_frame(8'h00, 8'd0, 1'b0, -1);
        payload_q = '{8'h80};
        send_frame(8'h7F, 8'd2, 1'b1, -1);
        payload_q = '{CMD_RESET, RESET_ARG};
        send_frame(BCAST_ADDR, 8'd3, 1'b0, -1);
      end
      while (n_items < N_ITEMS * (p + 1) / 3) begin
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(3, 1)) line_q.push_back(any_byte());
        random_frame();
      end
      if (p == 2) begin
        hold_req = 1'b1;
        wait (hold_off);
      end
      while (line_q.size() != 0 || in_valid || expected_beats.size() != 0) @(negedge clk);
    end
    repeat (8) @(negedge clk);
    $display("Sent %0d frames, %0d line bytes accepted, %0d address updates",
             n_frames, n_accepted, n_addr_updates);
    $display("Beats checked: data %0d, good end %0d, checksum error %0d, empty %0d",
             ev_seen[EV_DATA], ev_seen[EV_GOOD], ev_seen[EV_CSUM], ev_seen[EV_EMPTY]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d beats outstanding", expected_beats.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sfr_pkg.sv
rtl/core/serial_frame_receiver.sv
bench/tb.sv
